### hw/rtl/clnw_pkg.sv
// shared types, codes and the init strobe table for the character lcd nibble writer
// no dependencies; imported by clnw_ctrl, clnw_dp and char_lcd_nibble_writer
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

   // operation codes on the request tuser
   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_PUT     = 3'd1;
   localparam logic [2:0] OP_SET_POS = 3'd2;
   localparam logic [2:0] OP_SAVE    = 3'd3;
   localparam logic [2:0] OP_LOAD    = 3'd4;
   localparam logic [2:0] OP_CLEAR   = 3'd5;

   // wait codes carried with each strobe
   localparam logic [2:0] WAIT_1US   = 3'd0;
   localparam logic [2:0] WAIT_40US  = 3'd1;
   localparam logic [2:0] WAIT_80US  = 3'd2;
   localparam logic [2:0] WAIT_100US = 3'd3;
   localparam logic [2:0] WAIT_2MS   = 3'd4;
   localparam logic [2:0] WAIT_4MS   = 3'd5;

   // byte sources selected by the controller
   localparam logic [2:0] SRC_INIT  = 3'd0;
   localparam logic [2:0] SRC_POS   = 3'd1;
   localparam logic [2:0] SRC_SPACE = 3'd2;
   localparam logic [2:0] SRC_CHAR  = 3'd3;
   localparam logic [2:0] SRC_CLEAR = 3'd4;

   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] ROW_OFFSET    = 8'h40;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   localparam int INIT_STROBES = 14;

   typedef struct packed {
      logic       start;      // request beat taken this cycle
      logic       emit;       // strobe offered to the output register
      logic [2:0] src;
      logic       half;       // 0 high nibble, 1 low nibble
      logic       last;
      logic [3:0] init_step;
   } clnw_cmd_type;

   typedef struct packed {
      logic out_free;         // output register can take a strobe
      logic wrap;             // cursor is past the last column
   } clnw_stat_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic [2:0] wait_code;
   } clnw_strobe_type;

   // power-up sequence: three 0x3 nibbles, 0x2, then 0x28 0x0f 0x01 0x06 0x80
   function automatic clnw_strobe_type init_strobe(input logic [3:0] step);
      clnw_strobe_type s;
      case (step)
         4'd0:    s = '{4'h3, WAIT_4MS};
         4'd1:    s = '{4'h3, WAIT_100US};
         4'd2:    s = '{4'h3, WAIT_40US};
         4'd3:    s = '{4'h2, WAIT_40US};
         4'd4:    s = '{4'h2, WAIT_1US};
         4'd5:    s = '{4'h8, WAIT_80US};
         4'd6:    s = '{4'h0, WAIT_1US};
         4'd7:    s = '{4'hF, WAIT_80US};
         4'd8:    s = '{4'h0, WAIT_1US};
         4'd9:    s = '{4'h1, WAIT_2MS};
         4'd10:   s = '{4'h0, WAIT_1US};
         4'd11:   s = '{4'h6, WAIT_80US};
         4'd12:   s = '{4'h8, WAIT_1US};
         default: s = '{4'h0, WAIT_80US};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/clnw_ctrl.sv
// controller: sequences the strobes of each operation
// depends on clnw_pkg; drives clnw_dp through clnw_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module clnw_ctrl
   import clnw_pkg::*;
#(
   parameter int COLUMNS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [2:0]    req_op,
   input  wire clnw_stat_type stat,
   output clnw_cmd_type       cmd
);

   localparam int STEP_W = ($clog2(2 * COLUMNS) > 4) ? $clog2(2 * COLUMNS) : 4;
   localparam logic [STEP_W-1:0] BLANK_END = STEP_W'(2 * COLUMNS - 1);
   localparam logic [STEP_W-1:0] INIT_END  = STEP_W'(INIT_STROBES - 1);
   localparam logic [STEP_W-1:0] BYTE_END  = STEP_W'(1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_WPOS1  = 3'd2;
   localparam logic [2:0] ST_BLANK  = 3'd3;
   localparam logic [2:0] ST_WPOS2  = 3'd4;
   localparam logic [2:0] ST_CHAR   = 3'd5;
   localparam logic [2:0] ST_SETPOS = 3'd6;
   localparam logic [2:0] ST_CLEAR  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] step_end;
   logic [2:0]        after_end;
   logic              fire;
   logic              at_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign fire       = cmd.emit && stat.out_free;
   assign at_end     = (step_ff == step_end);

   always_comb begin
      cmd.start     = req_tvalid && req_tready;
      cmd.emit      = (state_ff != ST_IDLE);
      cmd.half      = step_ff[0];
      cmd.init_step = step_ff[3:0];
      cmd.src       = SRC_INIT;
      cmd.last      = 1'b0;
      step_end      = BYTE_END;
      after_end     = ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.src = SRC_INIT;
         end
         ST_INIT: begin
            cmd.src  = SRC_INIT;
            step_end = INIT_END;
            cmd.last = at_end;
         end
         ST_WPOS1: begin
            cmd.src   = SRC_POS;
            after_end = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.src   = SRC_SPACE;
            step_end  = BLANK_END;
            after_end = ST_WPOS2;
         end
         ST_WPOS2: begin
            cmd.src   = SRC_POS;
            after_end = ST_CHAR;
         end
         ST_CHAR: begin
            cmd.src  = SRC_CHAR;
            cmd.last = at_end;
         end
         ST_SETPOS: begin
            cmd.src  = SRC_POS;
            cmd.last = at_end;
         end
         ST_CLEAR: begin
            cmd.src  = SRC_CLEAR;
            cmd.last = at_end;
         end
         default: begin
            cmd.src = SRC_INIT;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (cmd.start) begin
         step_in = '0;
         unique case (req_op)
            OP_INIT:    state_in = ST_INIT;
            OP_PUT:     state_in = stat.wrap ? ST_WPOS1 : ST_CHAR;
            OP_SET_POS: state_in = ST_SETPOS;
            OP_LOAD:    state_in = ST_SETPOS;
            OP_CLEAR:   state_in = ST_CLEAR;
            default:    state_in = ST_IDLE;   // save and unused codes emit nothing
         endcase
      end else if (fire) begin
         if (at_end) begin
            step_in  = '0;
            state_in = after_end;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/clnw_dp.sv
// datapath: cursor and saved position, byte forming and the strobe output register
// depends on clnw_pkg; steered by clnw_ctrl through clnw_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module clnw_dp
   import clnw_pkg::*;
#(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [2:0]    req_op,
   input  wire logic [7:0]    req_char,
   input  wire logic [5:0]    req_column,
   input  wire logic [1:0]    req_row,
   input  wire clnw_cmd_type  cmd,
   output clnw_stat_type      stat,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   localparam logic [5:0] COL_LIMIT = 6'(COLUMNS);
   localparam logic [2:0] ROW_LIMIT = 3'(ROWS);

   logic [5:0] cur_col_ff, cur_col_in;
   logic [1:0] cur_row_ff, cur_row_in;
   logic [5:0] sav_col_ff, sav_col_in;
   logic [1:0] sav_row_ff, sav_row_in;
   logic [5:0] tgt_col_ff, tgt_col_in;
   logic [1:0] tgt_row_ff, tgt_row_in;
   logic [7:0] char_ff;

   logic       out_valid_ff;
   logic       out_rs_ff;
   logic [3:0] out_nib_ff;
   logic [2:0] out_wait_ff;
   logic       out_last_ff;

   logic [2:0]      next_row_wide;
   logic [1:0]      next_row;
   logic [7:0]      pos_byte;
   logic [7:0]      byte_val;
   logic            byte_rs;
   logic [2:0]      byte_wait;
   logic [3:0]      strobe_nib;
   logic [2:0]      strobe_wait;
   logic            fire;
   clnw_strobe_type init_s;

   assign stat.out_free = !out_valid_ff || rsp_tready;
   assign stat.wrap     = (cur_col_ff >= COL_LIMIT);
   assign fire          = cmd.emit && stat.out_free;

   // row after a wrap, back to row 0 at or past the last row
   assign next_row_wide = {1'b0, cur_row_ff} + 3'd1;
   assign next_row      = (next_row_wide >= ROW_LIMIT) ? 2'd0 : next_row_wide[1:0];

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      sav_col_in = sav_col_ff;
      sav_row_in = sav_row_ff;
      tgt_col_in = tgt_col_ff;
      tgt_row_in = tgt_row_ff;
      if (cmd.start) begin
         unique case (req_op) inside
            OP_INIT, OP_CLEAR: begin
               cur_col_in = '0;
               cur_row_in = '0;
            end
            OP_PUT: begin
               if (stat.wrap) begin
                  tgt_col_in = '0;
                  tgt_row_in = next_row;
                  cur_col_in = 6'd1;
                  cur_row_in = next_row;
               end else begin
                  cur_col_in = cur_col_ff + 6'd1;
               end
            end
            OP_SET_POS: begin
               tgt_col_in = req_column;
               tgt_row_in = req_row;
               cur_col_in = req_column;
               cur_row_in = req_row;
            end
            OP_LOAD: begin
               tgt_col_in = sav_col_ff;
               tgt_row_in = sav_row_ff;
               cur_col_in = sav_col_ff;
               cur_row_in = sav_row_ff;
            end
            OP_SAVE: begin
               sav_col_in = cur_col_ff;
               sav_row_in = cur_row_ff;
            end
            default: begin
               cur_col_in = cur_col_ff;
            end
         endcase
      end
   end

   assign pos_byte = CMD_SET_DDRAM + {2'b00, tgt_col_ff}
                     + ((tgt_row_ff == 2'd0) ? 8'h00 : ROW_OFFSET);
   assign init_s   = init_strobe(cmd.init_step);

   always_comb begin
      byte_val  = CMD_CLEAR;
      byte_rs   = 1'b0;
      byte_wait = WAIT_2MS;
      case (cmd.src)
         SRC_POS: begin
            byte_val  = pos_byte;
            byte_wait = WAIT_80US;
         end
         SRC_SPACE: begin
            byte_val  = CHAR_SPACE;
            byte_rs   = 1'b1;
            byte_wait = WAIT_40US;
         end
         SRC_CHAR: begin
            byte_val  = char_ff;
            byte_rs   = 1'b1;
            byte_wait = WAIT_40US;
         end
         default: begin
            byte_val = CMD_CLEAR;
         end
      endcase
      if (cmd.src == SRC_INIT) begin
         strobe_nib  = init_s.nibble;
         strobe_wait = init_s.wait_code;
      end else begin
         strobe_nib  = cmd.half ? byte_val[3:0] : byte_val[7:4];
         strobe_wait = cmd.half ? byte_wait : WAIT_1US;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sav_col_ff   <= '0;
         sav_row_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         sav_col_ff <= sav_col_in;
         sav_row_ff <= sav_row_in;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_col_ff <= tgt_col_in;
      tgt_row_ff <= tgt_row_in;
      if (cmd.start) begin
         char_ff <= req_char;
      end
      if (fire) begin
         out_rs_ff   <= (cmd.src == SRC_INIT) ? 1'b0 : byte_rs;
         out_nib_ff  <= strobe_nib;
         out_wait_ff <= strobe_wait;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_wait_ff, out_nib_ff, out_rs_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

### hw/rtl/char_lcd_nibble_writer.sv
// character lcd nibble writer, 4-bit bus front end
// usage: a request beat carries one operation (tuser) and its operands (tdata).
// each operation comes out as a run of strobe beats on rsp, tlast on the final one.
// a strobe beat holds register select, four data bits and a wait code to honor
// after the strobe; the high nibble of a byte goes first. save position and the
// unused operation codes give no beats.
// timing: once a request is taken, one strobe leaves per cycle while
// rsp_tready is high: init 14 beats, clear, set and load position 2 beats,
// put character 2 beats, or 2*COLUMNS+6 beats when the cursor is past the last
// column and the next row is blanked first. the strobe sequencer handles one
// operation at a time, so the next request is taken only after the last beat
// enters the output register.
// a stalled receiver holds the output register and the sequencer waits on it.
// reset clears the cursor and saved position to row 0 column 0 and drops rsp_tvalid.
// the power-up wait of the display before init is left to the caller.
// depends on clnw_pkg, clnw_ctrl, clnw_dp
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer
   import clnw_pkg::*;
#(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // char_code[7:0], column[13:8], row[15:14]
   input  wire logic [2:0]  req_tuser,   // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // register_select[0], nibble[4:1], wait_code[7:5]
   output logic             rsp_tlast
);

   clnw_cmd_type  cmd;
   clnw_stat_type stat;

   clnw_ctrl #(
      .COLUMNS (COLUMNS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   clnw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_column (req_tdata[13:8]),
      .req_row    (req_tdata[15:14]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### sim/char_lcd_nibble_writer_tb.sv
// self-checking testbench for char_lcd_nibble_writer: directed and random operations,
// strobe beats predicted per operation and checked in order by a scoreboard class
// depends on clnw_pkg and the char_lcd_nibble_writer rtl
`timescale 1ns / 1ps

module char_lcd_nibble_writer_tb;
   import clnw_pkg::*;

   localparam int COLUMNS = 16;
   localparam int ROWS    = 2;

   // operation codes the block ignores
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;
   localparam logic [7:0] CMD_FUNCTION   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

   typedef struct packed {
      logic       rs;
      logic [3:0] nibble;
      logic [2:0] wait_code;
      logic       last;
   } lcd_strobe_type;

   class lcd_strobe_board #(int COLS = 16, int NROWS = 2);
      logic [5:0]     cur_col;
      logic [1:0]     cur_row;
      logic [5:0]     mark_col;
      logic [1:0]     mark_row;
      lcd_strobe_type strobes_due[$];
      int             mismatches;

      function new();
         cur_col    = '0;
         cur_row    = '0;
         mark_col   = '0;
         mark_row   = '0;
         mismatches = 0;
      endfunction

      function void push_strobe(input logic rs, input logic [3:0] nib,
                                input logic [2:0] wait_code);
         lcd_strobe_type s;
         s.rs        = rs;
         s.nibble    = nib;
         s.wait_code = wait_code;
         s.last      = 1'b0;
         strobes_due.push_back(s);
      endfunction

      // high nibble first, the low nibble carries the execution wait
      function void push_byte(input logic rs, input logic [7:0] value,
                              input logic [2:0] wait_code);
         push_strobe(rs, value[7:4], WAIT_1US);
         push_strobe(rs, value[3:0], wait_code);
      endfunction

      function void move_cursor(input logic [5:0] col, input logic [1:0] row);
         logic [7:0] command;
         command = CMD_SET_DDRAM + {2'b00, col} + ((row != 2'd0) ? ROW_OFFSET : 8'h00);
         cur_col = col;
         cur_row = row;
         push_byte(RS_COMMAND, command, WAIT_80US);
      endfunction

      function void note_request(input logic [2:0] op, input logic [7:0] ch,
                                 input logic [5:0] col, input logic [1:0] row);
         int first;
         int next_row;
         first = strobes_due.size();
         case (op)
            OP_INIT: begin
               push_strobe(RS_COMMAND, NIB_WAKE, WAIT_4MS);
               push_strobe(RS_COMMAND, NIB_WAKE, WAIT_100US);
               push_strobe(RS_COMMAND, NIB_WAKE, WAIT_40US);
               push_strobe(RS_COMMAND, NIB_FOUR_BIT, WAIT_40US);
               push_byte(RS_COMMAND, CMD_FUNCTION, WAIT_80US);
               push_byte(RS_COMMAND, CMD_DISPLAY_ON, WAIT_80US);
               push_byte(RS_COMMAND, CMD_CLEAR, WAIT_2MS);
               push_byte(RS_COMMAND, CMD_ENTRY_MODE, WAIT_80US);
               push_byte(RS_COMMAND, CMD_SET_DDRAM, WAIT_80US);
               cur_col = '0;
               cur_row = '0;
            end
            OP_PUT: begin
               // past the last column: next row, blank it, readdress
               if (cur_col >= COLS) begin
                  next_row = cur_row + 1;
                  if (next_row >= NROWS)
                     next_row = 0;
                  move_cursor(6'd0, next_row[1:0]);
                  repeat (COLS) push_byte(RS_DATA, CHAR_SPACE, WAIT_40US);
                  move_cursor(6'd0, next_row[1:0]);
               end
               push_byte(RS_DATA, ch, WAIT_40US);
               cur_col = cur_col + 6'd1;
            end
            OP_SET_POS: move_cursor(col, row);
            OP_SAVE: begin
               mark_col = cur_col;
               mark_row = cur_row;
            end
            OP_LOAD: move_cursor(mark_col, mark_row);
            OP_CLEAR: begin
               push_byte(RS_COMMAND, CMD_CLEAR, WAIT_2MS);
               cur_col = '0;
               cur_row = '0;
            end
            default: ;
         endcase
         if (strobes_due.size() > first)
            strobes_due[strobes_due.size() - 1].last = 1'b1;
      endfunction

      task report(input string what, input int want, input int got);
         if (mismatches < 100)
            $display("%0t ns strobe mismatch, %s: expected %0h got %0h", $time, what, want, got);
         mismatches++;
      endtask

      task check_strobe(input logic [7:0] data, input logic tlast);
         lcd_strobe_type due;
         if (strobes_due.size() == 0) begin
            report("beat with none due, tdata", 0, data);
         end else begin
            due = strobes_due.pop_front();
            if (data[0] !== due.rs)
               report("register select", due.rs, data[0]);
            if (data[4:1] !== due.nibble)
               report("nibble", due.nibble, data[4:1]);
            if (data[7:5] !== due.wait_code)
               report("wait code", due.wait_code, data[7:5]);
            if (tlast !== due.last)
               report("tlast", due.last, tlast);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // char_code[7:0], column[13:8], row[15:14]
   logic [2:0]  req_tuser;    // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // register_select[0], nibble[4:1], wait_code[7:5]
   logic        rsp_tlast;

   bit hold_request;
   bit quiet_tail;

   lcd_strobe_board #(COLUMNS, ROWS) board;

   char_lcd_nibble_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task offer_request(input logic [2:0] op, input logic [7:0] ch,
                      input logic [5:0] col, input logic [1:0] row);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {row, col, ch};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, ch, col, row);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task take_strobes(input logic ready, input int cycles);
      repeat (cycles) begin
         rsp_tready <= ready;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_strobe(rsp_tdata, rsp_tlast);
      end
   endtask

   initial begin : strobe_sink
      bit hold_done;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request && !hold_done) begin
            // long hold-off so the block backs up into its request side
            hold_done = 1'b1;
            take_strobes(1'b0, 400);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            take_strobes(1'b0, $urandom_range(1, 11));
         end else begin
            take_strobes(1'b1, $urandom_range(1, 24));
         end
      end
   end

   initial begin : request_source
      int         k;
      int         pick;
      logic [2:0] op;
      logic [5:0] col;
      board = new();
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_INIT;
      reset      <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_request(OP_INIT, 8'h00, 6'd0, 2'd0);
      offer_request(OP_PUT, 8'h00, 6'd0, 2'd0);
      offer_request(OP_PUT, 8'hFF, 6'd63, 2'd3);
      // largest address byte
      offer_request(OP_SET_POS, 8'hFF, 6'd63, 2'd3);
      offer_request(OP_SAVE, 8'h00, 6'd0, 2'd0);
      offer_request(OP_SET_POS, 8'h00, 6'd0, 2'd0);
      offer_request(OP_LOAD, 8'hFF, 6'd63, 2'd3);
      // cursor beyond the grid on row 3, wrap lands on row 0
      offer_request(OP_PUT, 8'h41, 6'd0, 2'd0);
      offer_request(OP_CLEAR, 8'h00, 6'd0, 2'd0);
      offer_request(OP_RSVD6, 8'hA5, 6'd42, 2'd2);
      offer_request(OP_RSVD7, 8'h5A, 6'd21, 2'd1);
      offer_request(OP_SET_POS, 8'h00, 6'd15, 2'd0);
      offer_request(OP_PUT, 8'h7E, 6'd0, 2'd0);
      offer_request(OP_PUT, 8'h80, 6'd0, 2'd0);
      offer_request(OP_SAVE, 8'h00, 6'd0, 2'd0);
      offer_request(OP_SET_POS, 8'h00, 6'd39, 2'd1);
      // wrap from the last row back to row 0
      offer_request(OP_PUT, 8'h31, 6'd0, 2'd0);
      offer_request(OP_SET_POS, 8'h00, 6'd20, 2'd2);
      offer_request(OP_PUT, 8'h32, 6'd0, 2'd0);
      // init keeps the saved position
      offer_request(OP_INIT, 8'h00, 6'd0, 2'd0);
      offer_request(OP_LOAD, 8'h00, 6'd0, 2'd0);
      offer_request(OP_PUT, 8'h20, 6'd0, 2'd0);

      for (k = 0; k < 350; k++) begin
         if (k == 100)
            hold_request = 1'b1;
         if (k == 320)
            quiet_tail = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 55)
            op = OP_PUT;
         else if (pick < 70)
            op = OP_SET_POS;
         else if (pick < 76)
            op = OP_SAVE;
         else if (pick < 83)
            op = OP_LOAD;
         else if (pick < 88)
            op = OP_CLEAR;
         else if (pick < 93)
            op = OP_INIT;
         else
            op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
         // mostly near the end of a line so wraps come often
         if ($urandom_range(0, 3) == 0)
            col = 6'($urandom_range(0, 63));
         else
            col = 6'($urandom_range(8, 19));
         offer_request(op, 8'($urandom_range(0, 255)), col, 2'($urandom_range(0, 3)));
      end
      req_tvalid <= 1'b0;

      while (board.strobes_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.mismatches == 0 && board.strobes_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
